// ----- design/cle_pkg.sv -----
// Shared types and constants for the console line editor.
package cle_pkg;

  // Key kinds carried in the low bits of in_tuser
  localparam logic [3:0] KIND_CHAR  = 4'd0;
  localparam logic [3:0] KIND_ESC   = 4'd1;
  localparam logic [3:0] KIND_HOME  = 4'd2;
  localparam logic [3:0] KIND_END   = 4'd3;
  localparam logic [3:0] KIND_LEFT  = 4'd4;
  localparam logic [3:0] KIND_RIGHT = 4'd5;
  localparam logic [3:0] KIND_INS   = 4'd6;
  localparam logic [3:0] KIND_DEL   = 4'd7;
  localparam logic [3:0] KIND_F6    = 4'd8;

  // Configuration register indexes
  localparam logic [1:0] REG_LINE_MAX  = 2'd0;
  localparam logic [1:0] REG_WAKE_MASK = 2'd1;
  localparam logic [1:0] REG_PROC_IN   = 2'd2;

  // Character codes
  localparam logic [15:0] CH_BS    = 16'h0008;
  localparam logic [15:0] CH_LF    = 16'h000A;
  localparam logic [15:0] CH_CR    = 16'h000D;
  localparam logic [15:0] CH_CTRLZ = 16'h001A;
  localparam logic [15:0] CH_SPACE = 16'h0020;

  // Work plan chosen when a key beat is taken
  localparam logic [2:0] PLAN_NONE = 3'd0;
  localparam logic [2:0] PLAN_SHUP = 3'd1;
  localparam logic [2:0] PLAN_WR   = 3'd2;
  localparam logic [2:0] PLAN_SHDN = 3'd3;
  localparam logic [2:0] PLAN_WORD = 3'd4;
  localparam logic [2:0] PLAN_DONE = 3'd5;

  // Datapath operations issued by the controller
  localparam logic [3:0] OP_IDLE    = 4'd0;
  localparam logic [3:0] OP_ACCEPT  = 4'd1;
  localparam logic [3:0] OP_SU_RD   = 4'd2;
  localparam logic [3:0] OP_SU_WR   = 4'd3;
  localparam logic [3:0] OP_PUT     = 4'd4;
  localparam logic [3:0] OP_SD_RD   = 4'd5;
  localparam logic [3:0] OP_SD_WR   = 4'd6;
  localparam logic [3:0] OP_WJ_RD   = 4'd7;
  localparam logic [3:0] OP_WJ_CK   = 4'd8;
  localparam logic [3:0] OP_WJ_FIN  = 4'd9;
  localparam logic [3:0] OP_W1      = 4'd10;
  localparam logic [3:0] OP_W2      = 4'd11;
  localparam logic [3:0] OP_EM_RD   = 4'd12;
  localparam logic [3:0] OP_EM_LOAD = 4'd13;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] plan;
    logic       su_end;
    logic       sd_end;
    logic       wj_bound;
    logic       wj_go;
    logic       wj_phase;
    logic       w2_en;
    logic       em_last;
    logic       out_free;
  } stat_t;

endpackage

// ----- design/cle_datapath.sv -----
// Line store, cursor, configuration, key decode and output register.
module cle_datapath #(
  parameter int MAX_LINE = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [31:0]       cfg_wdata,
  input  logic [4:0]        in_tuser,
  input  logic [15:0]       in_tdata,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [15:0]       out_tdata,
  output logic              out_tlast,
  input  cle_pkg::cmd_t     cmd,
  output cle_pkg::stat_t    stat
);
  import cle_pkg::*;

  localparam int LW = $clog2(MAX_LINE + 1);
  localparam int AW = $clog2(MAX_LINE);
  localparam int EW = (LW > 7) ? LW : 7;
  localparam int SW = EW + 1;

  logic [15:0]   mem [MAX_LINE];
  logic [15:0]   rd_r;
  logic [AW-1:0] ra;
  logic          re;
  logic          we;
  logic [AW-1:0] wa;
  logic [15:0]   wd;

  logic [LW-1:0] cur_r, len_r, pos_r, idx_r, del_r, w2a_r;
  logic          insm_r, dir_r, phase_r, w2en_r;
  logic [15:0]   ch_r, w2d_r;
  logic [2:0]    plan_r;
  logic [6:0]    line_max_r;
  logic [31:0]   mask_r;
  logic          proc_r;
  logic          out_valid_r, out_last_r;
  logic [15:0]   out_char_r;

  // decode of the incoming key
  logic [3:0]    kind;
  logic          ctrl;
  logic [15:0]   chx;
  logic [SW-1:0] eff, nl;
  logic          e_go, e_ins, e_ok;
  logic [LW-1:0] e_pos, e_del;
  logic [LW-1:0] d_cur, d_len, d_pos, d_idx, d_w2a;
  logic          d_insm, d_dir, d_w2en;
  logic [15:0]   d_ch, d_w2d;
  logic [2:0]    d_plan;
  logic [LW:0]   em_next;

  assign kind = in_tuser[3:0];
  assign ctrl = in_tuser[4];
  assign chx  = (kind == KIND_F6) ? CH_CTRLZ : in_tdata;
  assign eff  = (SW'(line_max_r) > SW'(MAX_LINE)) ? SW'(MAX_LINE) : SW'(line_max_r);

  always_comb begin
    e_go   = 1'b0;
    e_pos  = cur_r;
    e_del  = '0;
    e_ins  = 1'b0;
    d_cur  = cur_r;
    d_len  = len_r;
    d_insm = insm_r;
    d_plan = PLAN_NONE;
    d_pos  = cur_r;
    d_idx  = '0;
    d_dir  = 1'b0;
    d_ch   = chx;
    d_w2en = 1'b0;
    d_w2a  = cur_r;
    d_w2d  = chx;
    case (kind)
      KIND_ESC: begin
        d_cur = '0;
        e_go  = 1'b1;
        e_pos = '0;
        e_del = len_r;
      end
      KIND_HOME: begin
        d_cur = '0;
        if (ctrl) begin
          e_go  = 1'b1;
          e_pos = '0;
          e_del = cur_r;
        end
      end
      KIND_END: begin
        if (ctrl) begin
          e_go  = 1'b1;
          e_del = len_r - cur_r;
        end else begin
          d_cur = len_r;
        end
      end
      KIND_LEFT: begin
        if (ctrl) begin
          d_plan = PLAN_WORD;
        end else if (cur_r != '0) begin
          d_cur = cur_r - LW'(1);
        end
      end
      KIND_RIGHT: begin
        if (ctrl) begin
          d_plan = PLAN_WORD;
          d_dir  = 1'b1;
        end else if (cur_r != len_r) begin
          d_cur = cur_r + LW'(1);
        end
      end
      KIND_INS: d_insm = ~insm_r;
      KIND_DEL: begin
        if (cur_r != len_r) begin
          e_go  = 1'b1;
          e_del = LW'(1);
        end
      end
      KIND_CHAR, KIND_F6: begin
        if (chx == CH_BS && proc_r) begin
          if (cur_r != '0) begin
            d_cur = cur_r - LW'(1);
            e_go  = 1'b1;
            e_pos = cur_r - LW'(1);
            e_del = LW'(1);
          end
        end else if (chx == CH_CR) begin
          d_cur  = len_r;
          d_plan = PLAN_DONE;
          d_pos  = len_r;
          d_ch   = CH_CR;
          d_len  = len_r + LW'(1);
          if (proc_r && (SW'(len_r) + SW'(1)) < eff) begin
            d_w2en = 1'b1;
            d_w2a  = len_r + LW'(1);
            d_w2d  = CH_LF;
            d_len  = len_r + LW'(2);
          end
        end else if (chx == '0) begin
          d_plan = PLAN_NONE;
        end else if (chx < CH_SPACE && mask_r[chx[4:0]]) begin
          // space at the end, then the wakeup character at the cursor
          d_plan = PLAN_DONE;
          d_pos  = len_r;
          d_ch   = CH_SPACE;
          d_len  = len_r + LW'(1);
          d_w2en = 1'b1;
          d_w2a  = cur_r;
          d_w2d  = chx;
        end else begin
          e_go  = 1'b1;
          e_ins = 1'b1;
          e_del = LW'(!insm_r && cur_r != len_r);
        end
      end
      default: d_plan = PLAN_NONE;
    endcase

    // room check for an edit: CR LF must still fit
    nl   = SW'(len_r) - SW'(e_del) + SW'(e_ins);
    e_ok = (nl + SW'(2)) <= eff;
    if (e_go && e_ok) begin
      d_len = nl[LW-1:0];
      d_cur = e_pos + LW'(e_ins);
      d_pos = e_pos;
      if (!e_ins) begin
        d_plan = PLAN_SHDN;
        d_idx  = e_pos;
      end else if (e_del != '0) begin
        d_plan = PLAN_WR;
      end else begin
        d_plan = PLAN_SHUP;
        d_idx  = len_r;
      end
    end
  end

  // memory ports per operation
  always_comb begin
    ra = '0;
    re = 1'b0;
    we = 1'b0;
    wa = pos_r[AW-1:0];
    wd = ch_r;
    case (cmd.op)
      OP_SU_RD: begin
        re = 1'b1;
        ra = AW'(idx_r - LW'(1));
      end
      OP_SU_WR: begin
        we = 1'b1;
        wa = idx_r[AW-1:0];
        wd = rd_r;
      end
      OP_PUT, OP_W1: we = 1'b1;
      OP_SD_RD: begin
        re = 1'b1;
        ra = AW'(idx_r + del_r);
      end
      OP_SD_WR: begin
        we = 1'b1;
        wa = idx_r[AW-1:0];
        wd = rd_r;
      end
      OP_WJ_RD: begin
        re = 1'b1;
        ra = dir_r ? pos_r[AW-1:0] : AW'(pos_r - LW'(1));
      end
      OP_W2: begin
        we = 1'b1;
        wa = w2a_r[AW-1:0];
        wd = w2d_r;
      end
      OP_EM_RD: begin
        re = 1'b1;
        ra = idx_r[AW-1:0];
      end
      default: ra = '0;
    endcase
  end

  // line store with registered read, held between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign em_next = {1'b0, idx_r} + (LW+1)'(1);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      len_r       <= '0;
      insm_r      <= 1'b1;
      line_max_r  <= 7'd64;
      mask_r      <= '0;
      proc_r      <= 1'b1;
      out_valid_r <= 1'b0;
      plan_r      <= PLAN_NONE;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_LINE_MAX:  line_max_r <= cfg_wdata[6:0];
          REG_WAKE_MASK: mask_r     <= cfg_wdata;
          REG_PROC_IN:   proc_r     <= cfg_wdata[0];
          default:       ;
        endcase
      end
      // load a new output beat, or drop the one taken
      if (cmd.op == OP_EM_LOAD) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_ACCEPT: begin
          cur_r  <= d_cur;
          len_r  <= d_len;
          insm_r <= d_insm;
          plan_r <= d_plan;
        end
        OP_WJ_FIN: cur_r <= pos_r;
        OP_EM_LOAD: begin
          if (em_next == (LW+1)'(len_r)) begin
            len_r <= '0;
            cur_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        pos_r   <= d_pos;
        idx_r   <= d_idx;
        del_r   <= e_del;
        dir_r   <= d_dir;
        phase_r <= 1'b0;
        ch_r    <= d_ch;
        w2en_r  <= d_w2en;
        w2a_r   <= d_w2a;
        w2d_r   <= d_w2d;
      end
      OP_SU_WR: idx_r <= idx_r - LW'(1);
      OP_SD_WR: idx_r <= idx_r + LW'(1);
      OP_WJ_CK: begin
        if (stat.wj_go) begin
          pos_r <= dir_r ? pos_r + LW'(1) : pos_r - LW'(1);
        end else begin
          phase_r <= 1'b1;
        end
      end
      OP_EM_LOAD: begin
        out_char_r <= rd_r;
        out_last_r <= (em_next == (LW+1)'(len_r));
        idx_r      <= idx_r + LW'(1);
      end
      default: ;
    endcase
  end

  // status back to the controller
  always_comb begin
    stat.plan     = plan_r;
    stat.su_end   = (idx_r == pos_r);
    stat.sd_end   = (idx_r == len_r);
    stat.wj_bound = dir_r ? (pos_r == len_r) : (pos_r == '0);
    stat.wj_go    = (rd_r == CH_SPACE) ^ dir_r ^ phase_r;
    stat.wj_phase = phase_r;
    stat.w2_en    = w2en_r;
    stat.em_last  = (em_next == (LW+1)'(len_r));
    stat.out_free = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- design/cle_ctrl.sv -----
// Controller state machine sequencing shifts, word jumps and line output.
module cle_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  cle_pkg::stat_t stat,
  output cle_pkg::cmd_t  cmd
);
  import cle_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_SU_RD  = 4'd2;
  localparam logic [3:0] S_SU_WR  = 4'd3;
  localparam logic [3:0] S_PUT    = 4'd4;
  localparam logic [3:0] S_SD_RD  = 4'd5;
  localparam logic [3:0] S_SD_WR  = 4'd6;
  localparam logic [3:0] S_WJ_RD  = 4'd7;
  localparam logic [3:0] S_WJ_CK  = 4'd8;
  localparam logic [3:0] S_W1     = 4'd9;
  localparam logic [3:0] S_W2     = 4'd10;
  localparam logic [3:0] S_EM_RD  = 4'd11;
  localparam logic [3:0] S_EM_OUT = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_ACCEPT;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.plan)
          PLAN_SHUP: state_nxt = S_SU_RD;
          PLAN_WR:   state_nxt = S_PUT;
          PLAN_SHDN: state_nxt = S_SD_RD;
          PLAN_WORD: state_nxt = S_WJ_RD;
          PLAN_DONE: state_nxt = S_W1;
          default:   state_nxt = S_IDLE;
        endcase
      end
      // open a gap at the cursor, tail first
      S_SU_RD: begin
        if (stat.su_end) begin
          state_nxt = S_PUT;
        end else begin
          cmd.op    = OP_SU_RD;
          state_nxt = S_SU_WR;
        end
      end
      S_SU_WR: begin
        cmd.op    = OP_SU_WR;
        state_nxt = S_SU_RD;
      end
      S_PUT: begin
        cmd.op    = OP_PUT;
        state_nxt = S_IDLE;
      end
      // close the hole, head first
      S_SD_RD: begin
        if (stat.sd_end) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_SD_RD;
          state_nxt = S_SD_WR;
        end
      end
      S_SD_WR: begin
        cmd.op    = OP_SD_WR;
        state_nxt = S_SD_RD;
      end
      // word jump: skip one class of characters, then the other
      S_WJ_RD: begin
        if (stat.wj_bound) begin
          cmd.op    = OP_WJ_FIN;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_WJ_RD;
          state_nxt = S_WJ_CK;
        end
      end
      S_WJ_CK: begin
        if (!stat.wj_go && stat.wj_phase) begin
          cmd.op    = OP_WJ_FIN;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_WJ_CK;
          state_nxt = S_WJ_RD;
        end
      end
      S_W1: begin
        cmd.op    = OP_W1;
        state_nxt = stat.w2_en ? S_W2 : S_EM_RD;
      end
      S_W2: begin
        cmd.op    = OP_W2;
        state_nxt = S_EM_RD;
      end
      // stream the finished line
      S_EM_RD: begin
        cmd.op    = OP_EM_RD;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (stat.out_free) begin
          cmd.op    = OP_EM_LOAD;
          state_nxt = stat.em_last ? S_IDLE : S_EM_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/console_line_editor_top.sv -----
// Top level of the console line editor: controller plus datapath.
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tuser: key_kind, ctrl_held; tdata: char_code
//  out_     out  out_tvalid/out_tready  tdata: out_char; tlast: out_last
//  cfg_     in   cfg_we                 cfg_addr index, cfg_wdata value
//
// A key beat is accepted, then dispatched; no new key is taken until its work
// ends. An edit shifts each character by a read and a write, then finishes
// (an insert also places the key); a word jump checks each character passed,
// switches class and stops. Enter or a wakeup key writes and streams the line.
// Synchronous active-low reset; the line store itself is not cleared.
// A stalled out_tready holds the output beat and the line stream behind it.
module console_line_editor_top #(
  parameter int MAX_LINE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [4:0]  in_tuser,   // [3:0] key_kind, [4] ctrl_held
  input  logic [15:0] in_tdata,   // [15:0] char_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] out_char
  output logic        out_tlast
);
  import cle_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cle_datapath #(
    .MAX_LINE (MAX_LINE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
